// ===== hdl/scr_pkg.sv =====
// shared types and constants for the sphere collision response pipeline
`timescale 1ns / 1ps

package scr_pkg;

    localparam int VEL_W      = 32;
    localparam int E_W        = 17;
    localparam logic [E_W-1:0] E_ONE = 17'h10000;
    localparam int UNIT_FRAC  = 30;
    localparam int W_FRAC     = 28;

    localparam int SQRT_X_W   = 64;
    localparam int SQRT_R_W   = 32;
    localparam int SQRT_REM_W = 35;

    localparam int DIV_NUM_W  = 64;
    localparam int DIV_DEN_W  = 33;
    localparam int DIV_Q_W    = 31;

    localparam logic [1:0] FAULT_NONE        = 2'd0;
    localparam logic [1:0] FAULT_ZERO_OFFSET = 2'd1;
    localparam logic [1:0] FAULT_ZERO_MASS   = 2'd2;

    typedef struct packed {
        logic signed [VEL_W-1:0] offset_x;
        logic signed [VEL_W-1:0] offset_y;
        logic signed [VEL_W-1:0] offset_z;
        logic signed [VEL_W-1:0] vel_a_x;
        logic signed [VEL_W-1:0] vel_a_y;
        logic signed [VEL_W-1:0] vel_a_z;
        logic signed [VEL_W-1:0] vel_b_x;
        logic signed [VEL_W-1:0] vel_b_y;
        logic signed [VEL_W-1:0] vel_b_z;
        logic        [VEL_W-1:0] mass_a;
        logic        [VEL_W-1:0] mass_b;
    } scr_in_t;

    typedef struct packed {
        logic signed [VEL_W-1:0] new_a_x;
        logic signed [VEL_W-1:0] new_a_y;
        logic signed [VEL_W-1:0] new_a_z;
        logic signed [VEL_W-1:0] new_b_x;
        logic signed [VEL_W-1:0] new_b_y;
        logic signed [VEL_W-1:0] new_b_z;
        logic        [1:0]       fault;
    } scr_out_t;

endpackage

// ===== hdl/scr_isqrt.sv =====
// pipelined floor integer square root, one root bit per stage
`timescale 1ns / 1ps

module scr_isqrt
    import scr_pkg::*;
(
    input  logic                clk,
    input  logic                adv,
    input  logic [SQRT_X_W-1:0] x,
    output logic [SQRT_R_W-1:0] root
);

    logic [SQRT_X_W-1:0]   x_reg    [SQRT_R_W];
    logic [SQRT_REM_W-1:0] rem_reg  [SQRT_R_W];
    logic [SQRT_R_W-1:0]   root_reg [SQRT_R_W];

    logic [SQRT_X_W-1:0]   x_cur     [SQRT_R_W];
    logic [SQRT_REM_W-1:0] rem_cur   [SQRT_R_W];
    logic [SQRT_R_W-1:0]   root_cur  [SQRT_R_W];
    logic [SQRT_X_W-1:0]   x_next    [SQRT_R_W];
    logic [SQRT_REM_W-1:0] rem_next  [SQRT_R_W];
    logic [SQRT_R_W-1:0]   root_next [SQRT_R_W];

    always_comb
    begin
        x_cur[0]    = x;
        rem_cur[0]  = '0;
        root_cur[0] = '0;
        for (int k = 1; k < SQRT_R_W; k++)
        begin
            x_cur[k]    = x_reg[k-1];
            rem_cur[k]  = rem_reg[k-1];
            root_cur[k] = root_reg[k-1];
        end
    end

    always_comb
    begin
        logic [SQRT_REM_W-1:0] rem_sh;
        logic [SQRT_REM_W-1:0] trial;
        for (int k = 0; k < SQRT_R_W; k++)
        begin
            rem_sh = {rem_cur[k][SQRT_REM_W-3:0], x_cur[k][SQRT_X_W-1 -: 2]};
            trial  = {{(SQRT_REM_W-SQRT_R_W-2){1'b0}}, root_cur[k], 2'b01};
            x_next[k] = x_cur[k] << 2;
            if (rem_sh >= trial)
            begin
                rem_next[k]  = rem_sh - trial;
                root_next[k] = {root_cur[k][SQRT_R_W-2:0], 1'b1};
            end
            else
            begin
                rem_next[k]  = rem_sh;
                root_next[k] = {root_cur[k][SQRT_R_W-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int k = 0; k < SQRT_R_W; k++)
            begin
                x_reg[k]    <= x_next[k];
                rem_reg[k]  <= rem_next[k];
                root_reg[k] <= root_next[k];
            end
        end
    end

    assign root = root_reg[SQRT_R_W-1];

endmodule

// ===== hdl/scr_div.sv =====
// pipelined restoring divider, one quotient bit per stage
`timescale 1ns / 1ps

module scr_div
    import scr_pkg::*;
(
    input  logic                 clk,
    input  logic                 adv,
    input  logic [DIV_NUM_W-1:0] num,
    input  logic [DIV_DEN_W-1:0] den,
    output logic [DIV_Q_W-1:0]   quo
);

    logic [DIV_DEN_W-1:0] rem_reg  [DIV_Q_W];
    logic [DIV_Q_W-1:0]   bits_reg [DIV_Q_W];
    logic [DIV_DEN_W-1:0] den_reg  [DIV_Q_W];
    logic [DIV_Q_W-1:0]   q_reg    [DIV_Q_W];

    logic [DIV_DEN_W-1:0] rem_cur   [DIV_Q_W];
    logic [DIV_Q_W-1:0]   bits_cur  [DIV_Q_W];
    logic [DIV_DEN_W-1:0] den_cur   [DIV_Q_W];
    logic [DIV_Q_W-1:0]   q_cur     [DIV_Q_W];
    logic [DIV_DEN_W-1:0] rem_next  [DIV_Q_W];
    logic [DIV_Q_W-1:0]   bits_next [DIV_Q_W];
    logic [DIV_Q_W-1:0]   q_next    [DIV_Q_W];

    // quotient is known to fit, so the top part of the numerator is below den
    always_comb
    begin
        rem_cur[0]  = num[DIV_NUM_W-1:DIV_Q_W];
        bits_cur[0] = num[DIV_Q_W-1:0];
        den_cur[0]  = den;
        q_cur[0]    = '0;
        for (int k = 1; k < DIV_Q_W; k++)
        begin
            rem_cur[k]  = rem_reg[k-1];
            bits_cur[k] = bits_reg[k-1];
            den_cur[k]  = den_reg[k-1];
            q_cur[k]    = q_reg[k-1];
        end
    end

    always_comb
    begin
        logic [DIV_DEN_W:0] rem_sh;
        logic [DIV_DEN_W:0] diff;
        for (int k = 0; k < DIV_Q_W; k++)
        begin
            rem_sh = {rem_cur[k], bits_cur[k][DIV_Q_W-1]};
            diff   = rem_sh - {1'b0, den_cur[k]};
            bits_next[k] = bits_cur[k] << 1;
            if (rem_sh >= {1'b0, den_cur[k]})
            begin
                rem_next[k] = diff[DIV_DEN_W-1:0];
                q_next[k]   = {q_cur[k][DIV_Q_W-2:0], 1'b1};
            end
            else
            begin
                rem_next[k] = rem_sh[DIV_DEN_W-1:0];
                q_next[k]   = {q_cur[k][DIV_Q_W-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int k = 0; k < DIV_Q_W; k++)
            begin
                rem_reg[k]  <= rem_next[k];
                bits_reg[k] <= bits_next[k];
                den_reg[k]  <= den_cur[k];
                q_reg[k]    <= q_next[k];
            end
        end
    end

    assign quo = q_reg[DIV_Q_W-1];

endmodule

// ===== hdl/sphere_collision_response_top.sv =====
// Throughput: one transaction per cycle; the whole pipeline advances together
// and holds while the output register is full and out_ready is low.
// Depth is set by the 32-stage square root and the 31-stage dividers.
// Reset clears every valid bit and sets restitution to 1.0.
`timescale 1ns / 1ps

module sphere_collision_response_top
    import scr_pkg::*;
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    input  scr_in_t         in_data,
    output logic            out_valid,
    input  logic            out_ready,
    output scr_out_t        out_data,
    input  logic            cfg_wr_en,
    input  logic [E_W-1:0]  cfg_wr_data
);

    localparam logic [DIV_Q_W-1:0] UNIT_ONE = DIV_Q_W'(1) << UNIT_FRAC;

    typedef struct packed {
        logic [2:0][VEL_W-1:0] va;
        logic [2:0][VEL_W-1:0] vb;
    } vel_t;

    typedef struct packed {
        vel_t                  v;
        logic [2:0]            neg;
        logic [1:0]            fault;
        logic [2:0][VEL_W-1:0] a;
        logic [49:0]           mka;
        logic [49:0]           mkb;
        logic [32:0]           msum;
    } side_t;

    typedef struct packed {
        vel_t       v;
        logic [2:0] neg;
        logic [1:0] fault;
    } dside_t;

    typedef struct packed {
        vel_t                    v;
        logic [2:0]              neg;
        logic [1:0]              fault;
        logic [2:0][DIV_Q_W-1:0] n;
        logic [DIV_Q_W-1:0]      wa;
        logic [DIV_Q_W-1:0]      wb;
    } pside_t;

    function automatic logic [VEL_W-1:0] sat_add(input logic [VEL_W-1:0] v,
                                                 input logic [42:0] chg);
        logic [43:0] s;
        s = {{12{v[VEL_W-1]}}, v} + {chg[42], chg};
        if (!s[43] && (s[42:31] != '0))
            sat_add = {1'b0, {(VEL_W-1){1'b1}}};
        else if (s[43] && (s[42:31] != '1))
            sat_add = {1'b1, {(VEL_W-1){1'b0}}};
        else
            sat_add = s[VEL_W-1:0];
    endfunction

    logic adv;
    logic [E_W-1:0] restitution_reg;

    // front stages
    scr_in_t in_reg;
    logic    s1_vld_reg, s2_vld_reg, s3_vld_reg, s4_vld_reg, s5_vld_reg;
    side_t   s2_side_reg, s3_side_reg, s4_side_reg, s5_side_reg;
    side_t   s2_side_next, s3_side_next;
    logic [VEL_W-1:0]      s2_mx_reg, s2_mx_next;
    logic [2:0][63:0]      s4_sq_reg;
    logic [63:0]           s5_len2_reg;

    // square root line
    logic [SQRT_R_W-1:0] len_root;
    logic [SQRT_R_W-1:0] sq_vld_reg;
    side_t               sq_side_reg [SQRT_R_W];

    // divider prep and line
    logic                  s6_vld_reg;
    logic [DIV_NUM_W-1:0]  s6_num_reg [5];
    logic [DIV_NUM_W-1:0]  s6_num_next [5];
    logic [DIV_DEN_W-1:0]  s6_len_reg, s6_msum_reg;
    dside_t                s6_side_reg;
    logic [DIV_Q_W-1:0]    dv_vld_reg;
    dside_t                dv_side_reg [DIV_Q_W];
    logic [DIV_Q_W-1:0]    quo [5];

    // back stages
    logic [7:0]               p_vld_reg;
    logic signed [63:0]       prod_a_reg [3], prod_b_reg [3];
    logic signed [63:0]       prod_a_next [3], prod_b_next [3];
    pside_t                   p1_side_reg, p1_side_next;
    pside_t                   p2_side_reg, p3_side_reg, p4_side_reg;
    pside_t                   p5_side_reg, p6_side_reg, p7_side_reg, p8_side_reg;
    logic signed [63:0]       sa_reg, sb_reg;
    logic [35:0]              pa_reg, pb_reg, pa_next, pb_next;
    logic [35:0]              mdiff_reg, mdiff_next;
    logic                     dneg_reg, dpos_reg, dneg_next, dpos_next;
    logic [48:0]              hia_reg, loa_reg, hib_reg, lob_reg;
    logic                     dneg5_reg, dpos5_reg;
    logic [39:0]              dla_reg, dlb_reg, dla_next, dlb_next;
    logic                     dla_neg_reg, dlb_neg_reg;
    logic [50:0]              mhi_a_reg [3], mlo_a_reg [3], mhi_b_reg [3], mlo_b_reg [3];
    logic [50:0]              mhi_a_next [3], mlo_a_next [3], mhi_b_next [3], mlo_b_next [3];
    logic [2:0]               sgn_a7_reg, sgn_b7_reg, sgn_a7_next, sgn_b7_next;
    logic [42:0]              chg_a_reg [3], chg_b_reg [3], chg_a_next [3], chg_b_next [3];

    scr_out_t out_reg, out_next;
    logic     out_valid_reg;

    assign adv       = !out_valid_reg || out_ready;
    assign in_ready  = adv;
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            restitution_reg <= E_ONE;
        else if (cfg_wr_en)
            restitution_reg <= cfg_wr_data;
    end

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg    <= 1'b0;
            s2_vld_reg    <= 1'b0;
            s3_vld_reg    <= 1'b0;
            s4_vld_reg    <= 1'b0;
            s5_vld_reg    <= 1'b0;
            sq_vld_reg    <= '0;
            s6_vld_reg    <= 1'b0;
            dv_vld_reg    <= '0;
            p_vld_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            s1_vld_reg    <= in_valid;
            s2_vld_reg    <= s1_vld_reg;
            s3_vld_reg    <= s2_vld_reg;
            s4_vld_reg    <= s3_vld_reg;
            s5_vld_reg    <= s4_vld_reg;
            sq_vld_reg    <= {sq_vld_reg[SQRT_R_W-2:0], s5_vld_reg};
            s6_vld_reg    <= sq_vld_reg[SQRT_R_W-1];
            dv_vld_reg    <= {dv_vld_reg[DIV_Q_W-2:0], s6_vld_reg};
            p_vld_reg     <= {p_vld_reg[6:0], dv_vld_reg[DIV_Q_W-1]};
            out_valid_reg <= p_vld_reg[7];
        end
    end

    // magnitudes, largest component, mass products, faults
    always_comb
    begin
        logic [2:0][VEL_W-1:0] offs;
        logic [17:0]           kfac;
        offs = {in_reg.offset_z, in_reg.offset_y, in_reg.offset_x};
        kfac = 18'(E_ONE) + 18'(restitution_reg);
        s2_side_next.v.va = {in_reg.vel_a_z, in_reg.vel_a_y, in_reg.vel_a_x};
        s2_side_next.v.vb = {in_reg.vel_b_z, in_reg.vel_b_y, in_reg.vel_b_x};
        for (int i = 0; i < 3; i++)
        begin
            s2_side_next.neg[i] = offs[i][VEL_W-1];
            s2_side_next.a[i]   = offs[i][VEL_W-1] ? (~offs[i] + 32'd1) : offs[i];
        end
        s2_mx_next = s2_side_next.a[0];
        if (s2_side_next.a[1] > s2_mx_next)
            s2_mx_next = s2_side_next.a[1];
        if (s2_side_next.a[2] > s2_mx_next)
            s2_mx_next = s2_side_next.a[2];
        s2_side_next.mka  = 50'(in_reg.mass_b) * 50'(kfac);
        s2_side_next.mkb  = 50'(in_reg.mass_a) * 50'(kfac);
        s2_side_next.msum = 33'(in_reg.mass_a) + 33'(in_reg.mass_b);
        if (offs == '0)
            s2_side_next.fault = FAULT_ZERO_OFFSET;
        else if (s2_side_next.msum == '0)
            s2_side_next.fault = FAULT_ZERO_MASS;
        else
            s2_side_next.fault = FAULT_NONE;
    end

    // shift the offset up until its largest component reaches 2^30
    always_comb
    begin
        logic [4:0] sh;
        sh = '0;
        for (int i = 0; i < 30; i++)
        begin
            if (s2_mx_reg[i])
                sh = 5'(30 - i);
        end
        if (s2_mx_reg[31] || s2_mx_reg[30])
            sh = '0;
        s3_side_next = s2_side_reg;
        for (int i = 0; i < 3; i++)
            s3_side_next.a[i] = s2_side_reg.a[i] << sh;
    end

    always_comb
    begin
        logic [DIV_DEN_W-1:0] len_ext;
        len_ext = {1'b0, len_root};
        for (int i = 0; i < 3; i++)
            s6_num_next[i] = 64'({sq_side_reg[SQRT_R_W-1].a[i], 30'b0})
                           + 64'(len_root[SQRT_R_W-1:1]);
        s6_num_next[3] = 64'({sq_side_reg[SQRT_R_W-1].mka, 12'b0})
                       + 64'(sq_side_reg[SQRT_R_W-1].msum[32:1]);
        s6_num_next[4] = 64'({sq_side_reg[SQRT_R_W-1].mkb, 12'b0})
                       + 64'(sq_side_reg[SQRT_R_W-1].msum[32:1]);
        if (len_ext == '0)
            s6_num_next[0] = s6_num_next[0];
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            in_reg      <= in_data;
            s2_side_reg <= s2_side_next;
            s2_mx_reg   <= s2_mx_next;
            s3_side_reg <= s3_side_next;
            s4_side_reg <= s3_side_reg;
            for (int i = 0; i < 3; i++)
                s4_sq_reg[i] <= 64'(s3_side_reg.a[i]) * 64'(s3_side_reg.a[i]);
            s5_side_reg <= s4_side_reg;
            s5_len2_reg <= s4_sq_reg[0] + s4_sq_reg[1] + s4_sq_reg[2];
            sq_side_reg[0] <= s5_side_reg;
            for (int k = 1; k < SQRT_R_W; k++)
                sq_side_reg[k] <= sq_side_reg[k-1];
            for (int i = 0; i < 5; i++)
                s6_num_reg[i] <= s6_num_next[i];
            s6_len_reg        <= {1'b0, len_root};
            s6_msum_reg       <= sq_side_reg[SQRT_R_W-1].msum;
            s6_side_reg.v     <= sq_side_reg[SQRT_R_W-1].v;
            s6_side_reg.neg   <= sq_side_reg[SQRT_R_W-1].neg;
            s6_side_reg.fault <= sq_side_reg[SQRT_R_W-1].fault;
            dv_side_reg[0] <= s6_side_reg;
            for (int k = 1; k < DIV_Q_W; k++)
                dv_side_reg[k] <= dv_side_reg[k-1];
        end
    end

    scr_isqrt u_isqrt (
        .clk  (clk),
        .adv  (adv),
        .x    (s5_len2_reg),
        .root (len_root)
    );

    genvar g;
    generate
        for (g = 0; g < 5; g++)
        begin : g_div
            scr_div u_div (
                .clk (clk),
                .adv (adv),
                .num (s6_num_reg[g]),
                .den ((g < 3) ? s6_len_reg : s6_msum_reg),
                .quo (quo[g])
            );
        end
    endgenerate

    // projections of both velocities onto the unit line
    always_comb
    begin
        logic signed [VEL_W-1:0] ns;
        dside_t ds;
        ds = dv_side_reg[DIV_Q_W-1];
        p1_side_next.v     = ds.v;
        p1_side_next.neg   = ds.neg;
        p1_side_next.fault = ds.fault;
        p1_side_next.wa    = quo[3];
        p1_side_next.wb    = quo[4];
        for (int i = 0; i < 3; i++)
        begin
            p1_side_next.n[i] = quo[i];
            ns = ds.neg[i] ? -$signed({1'b0, quo[i]}) : $signed({1'b0, quo[i]});
            prod_a_next[i] = ns * $signed(ds.v.va[i]);
            prod_b_next[i] = ns * $signed(ds.v.vb[i]);
        end
    end

    // round projections, then difference of projected speeds
    always_comb
    begin
        logic [63:0] ma, mb, ra, rb;
        logic [36:0] diff;
        ma = sa_reg[63] ? (~sa_reg + 64'd1) : sa_reg;
        mb = sb_reg[63] ? (~sb_reg + 64'd1) : sb_reg;
        ra = ma + (64'd1 << (UNIT_FRAC - 1));
        rb = mb + (64'd1 << (UNIT_FRAC - 1));
        pa_next = sa_reg[63] ? -{2'b0, ra[63:30]} : {2'b0, ra[63:30]};
        pb_next = sb_reg[63] ? -{2'b0, rb[63:30]} : {2'b0, rb[63:30]};
        diff = {pb_reg[35], pb_reg} - {pa_reg[35], pa_reg};
        mdiff_next = diff[36] ? 36'(~diff + 37'd1) : diff[35:0];
        dneg_next  = diff[36];
        dpos_next  = !diff[36] && (diff != '0);
    end

    // mass weighted change of projected speed, then change along the line
    always_comb
    begin
        logic [67:0] sa6, sb6;
        sa6 = 68'({hia_reg, 18'b0}) + 68'(loa_reg) + (68'd1 << (W_FRAC - 1));
        sb6 = 68'({hib_reg, 18'b0}) + 68'(lob_reg) + (68'd1 << (W_FRAC - 1));
        dla_next = sa6[67:28];
        dlb_next = sb6[67:28];
        for (int i = 0; i < 3; i++)
        begin
            mhi_a_next[i]  = 51'(dla_reg[39:20]) * 51'(p6_side_reg.n[i]);
            mlo_a_next[i]  = 51'(dla_reg[19:0]) * 51'(p6_side_reg.n[i]);
            mhi_b_next[i]  = 51'(dlb_reg[39:20]) * 51'(p6_side_reg.n[i]);
            mlo_b_next[i]  = 51'(dlb_reg[19:0]) * 51'(p6_side_reg.n[i]);
            sgn_a7_next[i] = dla_neg_reg ^ p6_side_reg.neg[i];
            sgn_b7_next[i] = dlb_neg_reg ^ p6_side_reg.neg[i];
        end
    end

    always_comb
    begin
        logic [71:0] s;
        for (int i = 0; i < 3; i++)
        begin
            s = 72'({mhi_a_reg[i], 20'b0}) + 72'(mlo_a_reg[i])
              + (72'd1 << (UNIT_FRAC - 1));
            chg_a_next[i] = sgn_a7_reg[i] ? -{1'b0, s[71:30]} : {1'b0, s[71:30]};
            s = 72'({mhi_b_reg[i], 20'b0}) + 72'(mlo_b_reg[i])
              + (72'd1 << (UNIT_FRAC - 1));
            chg_b_next[i] = sgn_b7_reg[i] ? -{1'b0, s[71:30]} : {1'b0, s[71:30]};
        end
    end

    // saturated sum; faulted transactions pass the velocities through
    always_comb
    begin
        logic [2:0][VEL_W-1:0] na, nb;
        for (int i = 0; i < 3; i++)
        begin
            if (p8_side_reg.fault == FAULT_NONE)
            begin
                na[i] = sat_add(p8_side_reg.v.va[i], chg_a_reg[i]);
                nb[i] = sat_add(p8_side_reg.v.vb[i], chg_b_reg[i]);
            end
            else
            begin
                na[i] = p8_side_reg.v.va[i];
                nb[i] = p8_side_reg.v.vb[i];
            end
        end
        out_next.new_a_x = na[0];
        out_next.new_a_y = na[1];
        out_next.new_a_z = na[2];
        out_next.new_b_x = nb[0];
        out_next.new_b_y = nb[1];
        out_next.new_b_z = nb[2];
        out_next.fault   = p8_side_reg.fault;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int i = 0; i < 3; i++)
            begin
                prod_a_reg[i] <= prod_a_next[i];
                prod_b_reg[i] <= prod_b_next[i];
                mhi_a_reg[i]  <= mhi_a_next[i];
                mlo_a_reg[i]  <= mlo_a_next[i];
                mhi_b_reg[i]  <= mhi_b_next[i];
                mlo_b_reg[i]  <= mlo_b_next[i];
                chg_a_reg[i]  <= chg_a_next[i];
                chg_b_reg[i]  <= chg_b_next[i];
            end
            p1_side_reg <= p1_side_next;

            sa_reg      <= prod_a_reg[0] + prod_a_reg[1] + prod_a_reg[2];
            sb_reg      <= prod_b_reg[0] + prod_b_reg[1] + prod_b_reg[2];
            p2_side_reg <= p1_side_reg;

            pa_reg      <= pa_next;
            pb_reg      <= pb_next;
            p3_side_reg <= p2_side_reg;

            mdiff_reg   <= mdiff_next;
            dneg_reg    <= dneg_next;
            dpos_reg    <= dpos_next;
            p4_side_reg <= p3_side_reg;

            hia_reg     <= 49'(mdiff_reg[35:18]) * 49'(p4_side_reg.wa);
            loa_reg     <= 49'(mdiff_reg[17:0]) * 49'(p4_side_reg.wa);
            hib_reg     <= 49'(mdiff_reg[35:18]) * 49'(p4_side_reg.wb);
            lob_reg     <= 49'(mdiff_reg[17:0]) * 49'(p4_side_reg.wb);
            dneg5_reg   <= dneg_reg;
            dpos5_reg   <= dpos_reg;
            p5_side_reg <= p4_side_reg;

            dla_reg     <= dla_next;
            dlb_reg     <= dlb_next;
            dla_neg_reg <= dneg5_reg;
            dlb_neg_reg <= dpos5_reg;
            p6_side_reg <= p5_side_reg;

            sgn_a7_reg  <= sgn_a7_next;
            sgn_b7_reg  <= sgn_b7_next;
            p7_side_reg <= p6_side_reg;

            p8_side_reg <= p7_side_reg;

            out_reg     <= out_next;
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_data.fault == FAULT_NONE ||
                       out_data.fault == FAULT_ZERO_OFFSET ||
                       out_data.fault == FAULT_ZERO_MASS))
        else $error("illegal fault code on output");

    // unit line components never exceed one
    assert property (@(posedge clk) disable iff (!rst_n)
        (p_vld_reg[0] && p1_side_reg.fault == FAULT_NONE) |->
            (p1_side_reg.n[0] <= UNIT_ONE && p1_side_reg.n[1] <= UNIT_ONE &&
             p1_side_reg.n[2] <= UNIT_ONE))
        else $error("unit vector component out of range");

    assert property (@(posedge clk) disable iff (!rst_n)
        !adv |=> ($stable(sq_vld_reg) && $stable(dv_vld_reg) && $stable(p_vld_reg)))
        else $error("pipeline moved during stall");

endmodule
